@@ src/scm_pkg.sv @@
// Shared types, constants and codes for the stereo crossfade mixer.
`timescale 1ns / 1ps

package scm_pkg;

  localparam int CountW  = 18;
  localparam int SampleW = 16;
  localparam int GainW   = 16;
  localparam int PosW    = 16;
  localparam int CoefW   = PosW + 1;
  localparam int NumLanes = 2;

  localparam logic [GainW-1:0] GainMax   = 16'd32768;
  localparam logic [GainW-1:0] GainReset = 16'd32768;
  localparam logic [CoefW-1:0] UnityQ16  = 17'd65536;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_MIX     = 2'd1,
    CMD_FADE_IN = 2'd2,
    CMD_PASS    = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FADE_LENGTH = 1'b0,
    REG_VOLUME_GAIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] len;
    logic [CountW-1:0] rem;
  } gain_req_t;

  typedef struct packed {
    logic             done;
    logic [CoefW-1:0] fo;
    logic [CoefW-1:0] fi;
  } gain_rsp_t;

  typedef struct packed {
    logic             start;
    logic [CoefW-1:0] fo;
    logic [CoefW-1:0] fi;
    logic [GainW-1:0] gain;
  } lane_req_t;

endpackage

@@ src/stereo_crossfade_mixer.sv @@
// Top level of the stereo crossfade mixer: control, frame counter, lanes and output register.
`timescale 1ns / 1ps

// Stereo crossfade mixer. Each request carries one stereo frame of the
// outgoing track (current_*) and the incoming track (next_*) plus a command:
// start loads the remaining-frame counter from fade_length and gives no
// result; mix outputs current*sqrt(1-t) + next*t^3 and counts one frame off,
// giving nothing once the counter is at zero; fade-in outputs next*t^3 while
// frames remain and next unscaled after that; pass outputs next with volume
// only. t is the fade position (length - remaining)/length in Q0.16. Every
// result is scaled by volume_gain (Q1.15, clamped to unity) and saturated to
// 16 bits; fade_active is high while frames of the fade still remain.
// One request is worked on at a time. A mix or fade-in frame runs through
// the coefficient unit, with its 16-step position divider (skipped when
// the length is zero or below the remaining count) and 17-step square
// root, and then through the four-stage lanes. Pass frames and fade-in
// frames after the fade go straight to the lanes. A finished
// result waits in the output register while the next request is taken.
// Write the configuration registers only while the block is idle.

module stereo_crossfade_mixer (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [scm_pkg::CountW-1:0]       cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic signed [scm_pkg::SampleW-1:0] current_left,
  input  logic signed [scm_pkg::SampleW-1:0] current_right,
  input  logic signed [scm_pkg::SampleW-1:0] next_left,
  input  logic signed [scm_pkg::SampleW-1:0] next_right,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [scm_pkg::SampleW-1:0] out_left,
  output logic signed [scm_pkg::SampleW-1:0] out_right,
  output logic                             fade_active
);
  import scm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GAIN,
    S_LANE,
    S_MERGE
  } state_t;

  state_t            state;
  logic [CountW-1:0] fade_length;
  logic [GainW-1:0]  volume_gain;
  logic [CountW-1:0] frames_remaining;
  logic              is_mix;
  logic              active;
  logic [GainW-1:0]  gain_clamped;

  gain_req_t gain_req;
  gain_rsp_t gain_rsp;
  lane_req_t lane_req;

  logic signed [SampleW-1:0] cur_q   [NumLanes];
  logic signed [SampleW-1:0] nxt_q   [NumLanes];
  logic signed [SampleW-1:0] lane_out [NumLanes];
  logic [NumLanes-1:0]       lane_done;

  logic in_take;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Values above unity act as unity.
  assign gain_clamped = (volume_gain > GainMax) ? GainMax : volume_gain;

  // Configuration registers: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_length <= '0;
      volume_gain <= GainReset;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_FADE_LENGTH: fade_length <= cfg_data;
        REG_VOLUME_GAIN: volume_gain <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the frame's samples for the lanes while it is worked on.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_q[0] <= current_left;
      cur_q[1] <= current_right;
      nxt_q[0] <= next_left;
      nxt_q[1] <= next_right;
    end
  end

  // Control: state, frame counter, coefficient and lane requests, and the
  // output register that merges the two lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frames_remaining <= '0;
      gain_req.start   <= 1'b0;
      lane_req.start   <= 1'b0;
      out_valid        <= 1'b0;
      is_mix           <= 1'b0;
      active           <= 1'b0;
    end else begin
      gain_req.start <= 1'b0;
      lane_req.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            gain_req.len <= fade_length;
            gain_req.rem <= frames_remaining;
            lane_req.gain <= gain_clamped;
            case (cmd_t'(command))
              CMD_START: begin
                frames_remaining <= fade_length;
              end
              CMD_MIX: begin
                // Drop the frame once the fade has run out.
                if (frames_remaining != '0) begin
                  gain_req.start   <= 1'b1;
                  is_mix           <= 1'b1;
                  active           <= (frames_remaining != CountW'(1));
                  frames_remaining <= frames_remaining - CountW'(1);
                  state            <= S_GAIN;
                end
              end
              CMD_FADE_IN: begin
                if (frames_remaining != '0) begin
                  gain_req.start   <= 1'b1;
                  is_mix           <= 1'b0;
                  active           <= (frames_remaining != CountW'(1));
                  frames_remaining <= frames_remaining - CountW'(1);
                  state            <= S_GAIN;
                end else begin
                  // Fade over: pass the incoming track at unity.
                  lane_req.start <= 1'b1;
                  lane_req.fo    <= '0;
                  lane_req.fi    <= UnityQ16;
                  active         <= 1'b0;
                  state          <= S_LANE;
                end
              end
              CMD_PASS: begin
                lane_req.start <= 1'b1;
                lane_req.fo    <= '0;
                lane_req.fi    <= UnityQ16;
                active         <= (frames_remaining != '0);
                state          <= S_LANE;
              end
              default: ;
            endcase
          end
        end
        S_GAIN: begin
          if (gain_rsp.done) begin
            // A fade-in frame ignores the outgoing track.
            lane_req.start <= 1'b1;
            lane_req.fo    <= is_mix ? gain_rsp.fo : '0;
            lane_req.fi    <= gain_rsp.fi;
            state          <= S_LANE;
          end
        end
        S_LANE: begin
          if (lane_done[0]) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          // Advance only when the output register is free.
          if (out_free) begin
            out_valid   <= 1'b1;
            out_left    <= lane_out[0];
            out_right   <= lane_out[1];
            fade_active <= active;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  scm_gain u_gain (
    .clk (clk),
    .rst (rst),
    .req (gain_req),
    .rsp (gain_rsp)
  );

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    scm_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .req    (lane_req),
      .cur    (cur_q[i]),
      .nxt    (nxt_q[i]),
      .sample (lane_out[i]),
      .done   (lane_done[i])
    );
  end

  // The coefficient unit only answers while the control waits for it.
  a_gain_done_in_gain: assert property (@(posedge clk) disable iff (rst)
    gain_rsp.done |-> state == S_GAIN)
    else $error("coefficient unit finished outside the wait state");

  // Both lanes run in lock step.
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1])
    else $error("stereo lanes out of step");

  // A loaded result reports whether frames of the fade remain.
  a_active_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE && out_free) |=> fade_active == (frames_remaining != '0))
    else $error("fade_active disagrees with the frame counter");

endmodule

@@ src/scm_gain.sv @@
// Fade coefficient unit: position divider, fade-out square root and fade-in cube.
`timescale 1ns / 1ps

module scm_gain (
  input  logic              clk,
  input  logic              rst,
  input  scm_pkg::gain_req_t req,
  output scm_pkg::gain_rsp_t rsp
);
  import scm_pkg::*;

  typedef enum logic [1:0] {
    G_IDLE,
    G_DIV,
    G_PREP,
    G_SQRT
  } gstate_t;

  gstate_t           state;
  logic [4:0]        step;
  logic [CountW-1:0] len;
  logic [CountW-1:0] rmd;
  logic [PosW-1:0]   t;
  logic [2*CoefW-1:0] rad;
  logic [CoefW+2:0]  acc;
  logic [CoefW-1:0]  root;
  logic [2*PosW-1:0] t2;
  logic [PosW-1:0]   fi;
  logic              done;

  logic [CountW:0]   rmd_sh;
  logic [CoefW+2:0]  acc_sh;
  logic [CoefW+2:0]  trial;
  logic [3*PosW-1:0] t3;

  assign rmd_sh = {rmd, 1'b0};
  assign acc_sh = {acc[CoefW:0], rad[2*CoefW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign t3     = t2 * t;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (req.start) begin
            len  <= req.len;
            step <= '0;
            if (req.len == '0 || req.rem > req.len) begin
              t     <= '0;
              state <= G_PREP;
            end else begin
              rmd   <= req.len - req.rem;
              state <= G_DIV;
            end
          end
        end
        G_DIV: begin
          // one quotient bit a cycle
          if (rmd_sh >= {1'b0, len}) begin
            rmd <= CountW'(rmd_sh - {1'b0, len});
            t   <= {t[PosW-2:0], 1'b1};
          end else begin
            rmd <= rmd_sh[CountW-1:0];
            t   <= {t[PosW-2:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'(PosW - 1)) begin
            state <= G_PREP;
          end
        end
        G_PREP: begin
          rad   <= {1'b0, UnityQ16 - {1'b0, t}, {PosW{1'b0}}};
          acc   <= '0;
          root  <= '0;
          step  <= '0;
          state <= G_SQRT;
        end
        G_SQRT: begin
          // two radicand bits a cycle; the cube settles alongside
          t2 <= t * t;
          fi <= t3[3*PosW-1:2*PosW];
          if (acc_sh >= trial) begin
            acc  <= acc_sh - trial;
            root <= {root[CoefW-2:0], 1'b1};
          end else begin
            acc  <= acc_sh;
            root <= {root[CoefW-2:0], 1'b0};
          end
          rad  <= {rad[2*CoefW-3:0], 2'b00};
          step <= step + 5'd1;
          if (step == 5'(CoefW - 1)) begin
            done  <= 1'b1;
            state <= G_IDLE;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.fo   = root;
  assign rsp.fi   = {1'b0, fi};

endmodule

@@ src/scm_lane.sv @@
// One channel lane: weighted sum of the two tracks, volume and saturation.
`timescale 1ns / 1ps

module scm_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  scm_pkg::lane_req_t                req,
  input  logic signed [scm_pkg::SampleW-1:0] cur,
  input  logic signed [scm_pkg::SampleW-1:0] nxt,
  output logic signed [scm_pkg::SampleW-1:0] sample,
  output logic                              done
);
  import scm_pkg::*;

  localparam int AccW  = 2 * SampleW + 2;
  localparam int ProdW = AccW + GainW + 1;
  localparam int ShW   = ProdW - 31;

  logic [2:0]              vld;
  logic signed [AccW-1:0]  p1;
  logic signed [AccW-1:0]  p2;
  logic signed [AccW-1:0]  acc;
  logic signed [ProdW-1:0] prod;
  logic signed [ShW-1:0]   sh;
  logic signed [SampleW-1:0] sat;

  assign sh = prod[ProdW-1:31];

  always_comb begin
    if (sh > ShW'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sh < -ShW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sh[SampleW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], req.start};
      done <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    p1   <= cur * $signed({1'b0, req.fo});
    p2   <= nxt * $signed({1'b0, req.fi});
    acc  <= p1 + p2;
    prod <= acc * $signed({1'b0, req.gain});
    if (vld[2]) begin
      sample <= sat;
    end
  end

endmodule
